>>> rtl/reservation_station_table_defines.svh
// ----------------------------------------------------------------------------
// Reservation station table: shared assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef RESERVATION_STATION_TABLE_DEFINES_SVH
`define RESERVATION_STATION_TABLE_DEFINES_SVH

// same-cycle implication
`define RSTAB_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSTAB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rstab_pkg.sv
// ----------------------------------------------------------------------------
// Reservation station table package
// Field widths, operation and status codes, and the control word that
// travels down the slot chain with each transaction.
// ----------------------------------------------------------------------------
package rstab_pkg;

  localparam int MODE_W       = 2;
  localparam int ROB_TAG_W    = 6;
  localparam int ENTRY_W      = 64;
  localparam int STATUS_W     = 2;
  localparam int SLOT_INDEX_W = 4;
  localparam int OCC_W        = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_CREATE  = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_LOOKUP  = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_MISS = 2'd2
  } status_t;

  // dead: create refused because the table was full at entry
  // done: slot allocated (create) or tag found (release, lookup)
  typedef struct packed {
    logic  valid;
    mode_t mode;
    logic  dead;
    logic  done;
  } rstab_ctl_t;

endpackage

>>> rtl/rstab_req_if.sv
// ----------------------------------------------------------------------------
// Reservation station table request channel
// Valid/ready channel carrying one table operation per transaction.
// ----------------------------------------------------------------------------
interface rstab_req_if import rstab_pkg::*;;

  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [ROB_TAG_W-1:0] rob_tag;
  logic [ENTRY_W-1:0]   entry_payload;

  modport source (output valid, output mode, output rob_tag, output entry_payload,
                  input ready);
  modport sink   (input valid, input mode, input rob_tag, input entry_payload,
                  output ready);

endinterface

>>> rtl/rstab_rsp_if.sv
// ----------------------------------------------------------------------------
// Reservation station table response channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface rstab_rsp_if import rstab_pkg::*;;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [SLOT_INDEX_W-1:0] slot_index;
  logic [ENTRY_W-1:0]      slot_payload;
  logic [OCC_W-1:0]        occupied_count;

  modport source (output valid, output status, output slot_index, output slot_payload,
                  output occupied_count, input ready);
  modport sink   (input valid, input status, input slot_index, input slot_payload,
                  input occupied_count, output ready);

endinterface

>>> rtl/rstab_cell.sv
// ----------------------------------------------------------------------------
// Reservation station slot cell
// Holds one slot (busy, mapping, tag, contents), acts on the transaction
// passing by and hands it to the next cell through its output registers, which load only while adv is high.
// ----------------------------------------------------------------------------
`include "reservation_station_table_defines.svh"

module rstab_cell import rstab_pkg::*; #(
  parameter int TAG_W     = 6,
  parameter int PAYLOAD_W = 64,
  parameter int IDX_W     = 4,
  parameter int INDEX     = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  rstab_ctl_t           in_ctl,
  input  logic [TAG_W-1:0]     in_tag,
  input  logic [PAYLOAD_W-1:0] in_data,
  input  logic [IDX_W-1:0]     in_idx,
  output rstab_ctl_t           out_ctl,
  output logic [TAG_W-1:0]     out_tag,
  output logic [PAYLOAD_W-1:0] out_data,
  output logic [IDX_W-1:0]     out_idx
);

  logic                 busy;
  logic                 mapped;
  logic [TAG_W-1:0]     tag;
  logic [PAYLOAD_W-1:0] contents;

  logic                 tag_eq;
  logic                 alloc;
  logic                 unmap;
  logic                 hit;
  logic                 drop;
  rstab_ctl_t           ctl_next;
  logic [PAYLOAD_W-1:0] data_next;
  logic [IDX_W-1:0]     idx_next;

  always_comb begin
    tag_eq = mapped && (tag == in_tag);
    alloc  = 1'b0;
    unmap  = 1'b0;
    hit    = 1'b0;
    drop   = 1'b0;
    if (in_ctl.valid) begin
      case (in_ctl.mode)
        MODE_CREATE: begin
          if (!in_ctl.dead) begin
            if (!in_ctl.done && !busy) begin
              alloc = 1'b1;
            end else if (tag_eq) begin
              unmap = 1'b1;
            end
          end
        end
        MODE_RELEASE: begin
          hit  = !in_ctl.done && busy && tag_eq;
          drop = hit;
        end
        MODE_LOOKUP: begin
          hit = !in_ctl.done && busy && tag_eq;
        end
        MODE_CLEAR: begin
          drop = 1'b1;
        end
        default: begin
        end
      endcase
    end
    ctl_next      = in_ctl;
    ctl_next.done = in_ctl.done | alloc | hit;
    idx_next      = (alloc || hit) ? IDX_W'(INDEX) : in_idx;
    data_next     = (hit && in_ctl.mode == MODE_LOOKUP) ? contents : in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      mapped  <= 1'b0;
      out_ctl <= '0;
    end else if (adv) begin
      if (alloc) begin
        busy   <= 1'b1;
        mapped <= 1'b1;
      end else if (drop) begin
        busy   <= 1'b0;
        mapped <= 1'b0;
      end else if (unmap) begin
        mapped <= 1'b0;
      end
      out_ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (alloc) begin
        tag      <= in_tag;
        contents <= in_data;
      end
      out_tag  <= in_tag;
      out_data <= data_next;
      out_idx  <= idx_next;
    end
  end

  `RSTAB_ASSERT_IMPLIES(a_mapped_busy, mapped, busy, "mapped slot is not busy")
  `RSTAB_ASSERT_NEXT(a_alloc_sets, adv && alloc, busy && mapped && tag == $past(in_tag),
    "allocation did not take the slot")

endmodule

>>> rtl/reservation_station_table.sv
// ----------------------------------------------------------------------------
// Reservation station table
// A row of slot cells; a transaction moves one cell per cycle unless stalled.
// ----------------------------------------------------------------------------
// req carries mode, rob_tag and entry_payload: create takes the lowest free
// slot, release and lookup act on the slot mapped to rob_tag, clear frees
// every slot. rsp carries status, slot_index, slot_payload and the number
// of busy slots after the operation, one transaction per request.
// Result path: the transaction passes the output registers of every slot
// cell in turn, and the result is then loaded into the response register.
// Requests: no new request is taken until the previous one has left the
// row; req.ready rises at the edge that loads the result, and one transaction
// is in flight at a time.
// Reset: all slots free and the busy count zero; no request is taken while
// rst is high and the response register is emptied.
// Stall: a result waits in the response register while rsp.ready is low;
// the next request may still be accepted and walks the row, then holds at
// the last cell until the response register frees up.
// ----------------------------------------------------------------------------
`include "reservation_station_table_defines.svh"

module reservation_station_table import rstab_pkg::*; #(
  parameter int SLOT_COUNT   = 10,
  parameter int TAG_BITS     = 6,
  parameter int PAYLOAD_BITS = 64
) (
  input logic        clk,
  input logic        rst,
  rstab_req_if.sink   req,
  rstab_rsp_if.source rsp
);

  localparam int IdxW = $clog2(SLOT_COUNT);
  localparam int CntW = $clog2(SLOT_COUNT + 1);
  localparam int TagW = (TAG_BITS < ROB_TAG_W) ? TAG_BITS : ROB_TAG_W;

  rstab_ctl_t              ctl  [SLOT_COUNT+1];
  logic [TagW-1:0]         tagv [SLOT_COUNT+1];
  logic [PAYLOAD_BITS-1:0] datav[SLOT_COUNT+1];
  logic [IdxW-1:0]         idxv [SLOT_COUNT+1];

  logic                    walking;
  logic                    rsp_valid;
  logic [CntW-1:0]         count;
  status_t                 res_status;
  logic [IdxW-1:0]         res_index;
  logic [PAYLOAD_BITS-1:0] res_payload;

  logic                    accept;
  logic                    adv;
  logic                    exit_valid;
  status_t                 status_next;
  logic [IdxW-1:0]         index_next;
  logic [PAYLOAD_BITS-1:0] payload_next;
  logic [CntW-1:0]         count_next;

  assign req.ready = !walking && !rst;
  assign accept    = req.valid && !walking && !rst;
  assign exit_valid = ctl[SLOT_COUNT].valid;
  assign adv       = !(exit_valid && rsp_valid && !rsp.ready);

  always_comb begin
    ctl[0].valid = accept;
    ctl[0].mode  = mode_t'(req.mode);
    ctl[0].dead  = (count == CntW'(SLOT_COUNT));
    ctl[0].done  = 1'b0;
    tagv[0]      = req.rob_tag[TagW-1:0];
    datav[0]     = req.entry_payload[PAYLOAD_BITS-1:0];
    idxv[0]      = '0;
  end

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    rstab_cell #(
      .TAG_W     (TagW),
      .PAYLOAD_W (PAYLOAD_BITS),
      .IDX_W     (IdxW),
      .INDEX     (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_ctl   (ctl[i]),
      .in_tag   (tagv[i]),
      .in_data  (datav[i]),
      .in_idx   (idxv[i]),
      .out_ctl  (ctl[i+1]),
      .out_tag  (tagv[i+1]),
      .out_data (datav[i+1]),
      .out_idx  (idxv[i+1])
    );
  end

  always_comb begin
    status_next  = STATUS_OK;
    index_next   = '0;
    payload_next = '0;
    count_next   = count;
    case (ctl[SLOT_COUNT].mode)
      MODE_CREATE: begin
        if (ctl[SLOT_COUNT].dead) begin
          status_next = STATUS_FULL;
        end else begin
          index_next = idxv[SLOT_COUNT];
          count_next = count + CntW'(1);
        end
      end
      MODE_RELEASE: begin
        if (ctl[SLOT_COUNT].done) begin
          index_next = idxv[SLOT_COUNT];
          if (count != '0) begin
            count_next = count - CntW'(1);
          end
        end else begin
          status_next = STATUS_MISS;
        end
      end
      MODE_LOOKUP: begin
        if (ctl[SLOT_COUNT].done) begin
          index_next   = idxv[SLOT_COUNT];
          payload_next = datav[SLOT_COUNT];
        end else begin
          status_next = STATUS_MISS;
        end
      end
      MODE_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walking   <= 1'b0;
      rsp_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (accept) begin
        walking <= 1'b1;
      end
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (exit_valid && adv) begin
        rsp_valid <= 1'b1;
        walking   <= 1'b0;
        count     <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exit_valid && adv) begin
      res_status  <= status_next;
      res_index   <= index_next;
      res_payload <= payload_next;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.status         = res_status;
  assign rsp.slot_index     = SLOT_INDEX_W'(res_index);
  assign rsp.slot_payload   = ENTRY_W'(res_payload);
  assign rsp.occupied_count = OCC_W'(count);

  `RSTAB_ASSERT_IMPLIES(a_count_range, 1'b1, count <= CntW'(SLOT_COUNT),
    "busy count above slot count")
  `RSTAB_ASSERT_IMPLIES(a_exit_in_walk, exit_valid, walking,
    "transaction leaves the row with none in flight")
  `RSTAB_ASSERT_NEXT(a_full_keeps_count, exit_valid && adv && ctl[SLOT_COUNT].dead
    && ctl[SLOT_COUNT].mode == MODE_CREATE,
    count == $past(count) && res_status == STATUS_FULL, "refused create changed count")
  `RSTAB_ASSERT_NEXT(a_single_walk, accept, !req.ready, "second transaction accepted")

endmodule

>>> dv/reservation_station_table_test.sv
// ----------------------------------------------------------------------------
// Reservation station table testbench
// Sends create, release, lookup and clear operations: a directed opening
// (empty-table misses, payload extremes, duplicate tags, full table, clear),
// then randomized phases that reuse recent tags so that most releases and
// lookups hit. A shadow copy of the slot table predicts every response;
// responses are checked field by field in order. Both channels idle at
// random, except during one phase. The response side holds off once for a
// long stretch so that the table stalls its request channel.
// ----------------------------------------------------------------------------
module reservation_station_table_test;
  import rstab_pkg::*;

  localparam int TABLE_SLOTS    = 10;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 3 * TABLE_SLOTS;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RECENT_DEPTH   = 12;

  typedef struct packed {
    mode_t                mode;
    logic [ROB_TAG_W-1:0] tag;
    logic [ENTRY_W-1:0]   payload;
  } table_op_t;

  typedef struct packed {
    status_t                 status;
    logic [SLOT_INDEX_W-1:0] index;
    logic [ENTRY_W-1:0]      payload;
    logic [OCC_W-1:0]        occupied;
  } table_result_t;

  logic clk = 1'b0;
  logic rst;

  rstab_req_if req_ch ();
  rstab_rsp_if rsp_ch ();

  reservation_station_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow slot table
  logic                 slot_busy_m   [TABLE_SLOTS];
  logic                 slot_mapped_m [TABLE_SLOTS];
  logic [ROB_TAG_W-1:0] slot_tag_m    [TABLE_SLOTS];
  logic [ENTRY_W-1:0]   slot_data_m   [TABLE_SLOTS];
  int                   busy_total;

  table_op_t            pending_ops[$];
  table_result_t        table_results[$];
  logic [ROB_TAG_W-1:0] recent_tags[$];

  logic          req_fire = 1'b0;
  logic          rsp_fire = 1'b0;
  logic          idle_on = 1'b1;
  logic          hold_done = 1'b0;
  int            hold_left = 0;
  int            ops_pushed = 0;
  int            results_seen = 0;
  int            quiet_cycles = 0;
  int            errors = 0;
  table_op_t     next_op;
  table_op_t     seen_op;
  table_result_t want;

  function automatic table_result_t run_table_op(table_op_t op);
    table_result_t res;
    int            hit;
    int            i;
    res = '0;
    res.status = STATUS_OK;
    hit = -1;
    case (op.mode)
      MODE_CREATE: begin
        for (i = 0; i < TABLE_SLOTS; i++)
          if (hit < 0 && !slot_busy_m[i]) hit = i;
        if (hit < 0) begin
          res.status = STATUS_FULL;
        end else begin
          for (i = 0; i < TABLE_SLOTS; i++)
            if (slot_mapped_m[i] && slot_tag_m[i] == op.tag) slot_mapped_m[i] = 1'b0;
          slot_busy_m[hit]   = 1'b1;
          slot_mapped_m[hit] = 1'b1;
          slot_tag_m[hit]    = op.tag;
          slot_data_m[hit]   = op.payload;
          busy_total++;
          res.index = hit[SLOT_INDEX_W-1:0];
        end
      end
      MODE_RELEASE, MODE_LOOKUP: begin
        for (i = 0; i < TABLE_SLOTS; i++)
          if (hit < 0 && slot_busy_m[i] && slot_mapped_m[i] && slot_tag_m[i] == op.tag)
            hit = i;
        if (hit < 0) begin
          res.status = STATUS_MISS;
        end else begin
          res.index = hit[SLOT_INDEX_W-1:0];
          if (op.mode == MODE_RELEASE) begin
            slot_busy_m[hit]   = 1'b0;
            slot_mapped_m[hit] = 1'b0;
            if (busy_total > 0) busy_total--;
          end else begin
            res.payload = slot_data_m[hit];
          end
        end
      end
      default: begin
        for (i = 0; i < TABLE_SLOTS; i++) begin
          slot_busy_m[i]   = 1'b0;
          slot_mapped_m[i] = 1'b0;
        end
        busy_total = 0;
      end
    endcase
    res.occupied = busy_total[OCC_W-1:0];
    return res;
  endfunction

  task automatic check_field(string field, logic [ENTRY_W-1:0] want_v, logic [ENTRY_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want_v, got_v);
      errors++;
    end
  endtask

  task automatic queue_op(mode_t mode, logic [ROB_TAG_W-1:0] tag, logic [ENTRY_W-1:0] payload);
    table_op_t op;
    op.mode    = mode;
    op.tag     = tag;
    op.payload = payload;
    pending_ops = {pending_ops, op};
    ops_pushed++;
  endtask

  task automatic queue_random_ops(int count, int create_pct);
    int                   n;
    int                   roll;
    mode_t                mode;
    logic [ROB_TAG_W-1:0] tag;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 3) mode = MODE_CLEAR;
      else if (roll < 3 + create_pct) mode = MODE_CREATE;
      else if (roll < 3 + create_pct + (97 - create_pct) / 2) mode = MODE_RELEASE;
      else mode = MODE_LOOKUP;
      if (recent_tags.size() > 0 && $urandom_range(99) < (mode == MODE_CREATE ? 10 : 75))
        tag = recent_tags[$urandom_range(recent_tags.size() - 1)];
      else
        tag = ROB_TAG_W'($urandom_range((1 << ROB_TAG_W) - 1));
      if (mode == MODE_CREATE) begin
        recent_tags = {recent_tags, tag};
        if (recent_tags.size() > RECENT_DEPTH) void'(recent_tags.pop_front());
      end
      queue_op(mode, tag, {$urandom, $urandom});
    end
  endtask

  task automatic wait_for_drain();
    while (results_seen != ops_pushed) @(negedge clk);
    @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      if (pending_ops.size() > 0 && !(idle_on && $urandom_range(99) < 13)) begin
        next_op = pending_ops.pop_front();
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= next_op.mode;
        req_ch.rob_tag       <= next_op.tag;
        req_ch.entry_payload <= next_op.payload;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // response receiver, with one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!hold_done && results_seen >= 200) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= !(idle_on && $urandom_range(99) < 13);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    req_fire = !rst && req_ch.valid && req_ch.ready;
    rsp_fire = !rst && rsp_ch.valid && rsp_ch.ready;
    if (req_fire) begin
      seen_op.mode    = mode_t'(req_ch.mode);
      seen_op.tag     = req_ch.rob_tag;
      seen_op.payload = req_ch.entry_payload;
      table_results = {table_results, run_table_op(seen_op)};
    end
    if (rsp_fire) begin
      if (table_results.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, actual status %0d index %0d",
                 $time, rsp_ch.status, rsp_ch.slot_index);
        errors++;
      end else begin
        want = table_results.pop_front();
        check_field("status", ENTRY_W'(want.status), ENTRY_W'(rsp_ch.status));
        check_field("slot_index", ENTRY_W'(want.index), ENTRY_W'(rsp_ch.slot_index));
        check_field("slot_payload", want.payload, rsp_ch.slot_payload);
        check_field("occupied_count", ENTRY_W'(want.occupied),
                    ENTRY_W'(rsp_ch.occupied_count));
      end
      results_seen++;
    end
    if (req_fire || rsp_fire) quiet_cycles = 0;
    else quiet_cycles++;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("reservation_station_table_test NOT OK");
    $finish;
  end

  initial begin
    int i;
    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.mode          = MODE_CREATE;
    req_ch.rob_tag       = '0;
    req_ch.entry_payload = '0;
    rsp_ch.ready         = 1'b0;
    for (i = 0; i < TABLE_SLOTS; i++) begin
      slot_busy_m[i]   = 1'b0;
      slot_mapped_m[i] = 1'b0;
    end
    busy_total = 0;

    // directed: misses on empty table, payload extremes, duplicate tag,
    // fill to full, reuse of a freed slot, clear
    queue_op(MODE_LOOKUP, '0, '0);
    queue_op(MODE_RELEASE, '1, '1);
    queue_op(MODE_CREATE, '0, '0);
    queue_op(MODE_CREATE, '1, '1);
    queue_op(MODE_LOOKUP, '1, '0);
    queue_op(MODE_LOOKUP, '0, '1);
    queue_op(MODE_CREATE, '0, 64'hA5A5_5A5A_F00F_0FF0);
    queue_op(MODE_LOOKUP, '0, '0);
    queue_op(MODE_RELEASE, '0, '0);
    queue_op(MODE_LOOKUP, '0, '0);
    for (i = 1; i <= 8; i++) queue_op(MODE_CREATE, ROB_TAG_W'(i), {$urandom, $urandom});
    queue_op(MODE_CREATE, 6'd9, '1);
    queue_op(MODE_RELEASE, 6'd5, '0);
    queue_op(MODE_CREATE, 6'd42, 64'h8000_0000_0000_0001);
    queue_op(MODE_CLEAR, '1, '1);
    queue_op(MODE_LOOKUP, 6'd42, '0);
    queue_op(MODE_CREATE, 6'd21, 64'h7FFF_FFFF_FFFF_FFFE);

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    wait_for_drain();
    queue_random_ops(600, 55);
    wait_for_drain();
    idle_on = 1'b0;
    queue_random_ops(600, 40);
    wait_for_drain();
    idle_on = 1'b1;
    queue_random_ops(576, 48);
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0 && table_results.size() == 0) begin
      $display("reservation_station_table_test OK");
    end else begin
      $display("reservation_station_table_test NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/rstab_pkg.sv
rtl/rstab_req_if.sv
rtl/rstab_rsp_if.sv
rtl/rstab_cell.sv
rtl/reservation_station_table.sv
dv/reservation_station_table_test.sv
